[rtl/assert_macros.svh]
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property holds at every edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed: condition does not hold");

// when pre holds, post holds in the next cycle
`define ASSERT_NEXT(lbl, clk, rst, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed: next-cycle condition does not hold");

`else

`define ASSERT_ALWAYS(lbl, clk, rst, cond)
`define ASSERT_NEXT(lbl, clk, rst, pre, post)

`endif

`endif

[rtl/mlp_pkg.sv]
`default_nettype none

package mlp_pkg;

  localparam logic [7:0]  CR_CODE     = 8'd13;
  localparam logic [7:0]  CHAR_A      = 8'd65;
  localparam logic [7:0]  CHAR_Z      = 8'd90;
  localparam logic [4:0]  SYM_NONE    = 5'd0;
  localparam logic [4:0]  SYM_LAST    = 5'd26;
  localparam logic [4:0]  SYM_INVALID = 5'd27;

  localparam logic [15:0] DOT_RESET   = 16'd200;
  localparam logic [15:0] DASH_RESET  = 16'd1000;
  localparam logic [15:0] GAP_RESET   = 16'd200;
  localparam logic [15:0] ERROR_RESET = 16'd1000;

  typedef enum logic [1:0] {
    REG_DOT_TIME   = 2'd0,
    REG_DASH_TIME  = 2'd1,
    REG_GAP_TIME   = 2'd2,
    REG_ERROR_TIME = 2'd3
  } cfg_reg_t;

  // tone_led sits in bit 0
  typedef struct packed {
    logic [4:0] symbol_code;
    logic       dropped;
    logic       busy_res;
    logic       red_led;
    logic       tone_led;
  } result_t;

  // number of elements per letter, letter 0 is A
  function automatic logic [2:0] morse_len(input logic [4:0] letter);
    logic [2:0] n;
    unique case (letter)
      5'd4, 5'd19: n = 3'd1;
      5'd0, 5'd8, 5'd12, 5'd13: n = 3'd2;
      5'd3, 5'd6, 5'd10, 5'd14, 5'd17, 5'd18, 5'd20, 5'd22: n = 3'd3;
      default: n = 3'd4;
    endcase
    return n;
  endfunction

  // bit i set means element i is a dash
  function automatic logic [3:0] morse_bits(input logic [4:0] letter);
    logic [3:0] b;
    unique case (letter)
      5'd0:  b = 4'd2;
      5'd1:  b = 4'd1;
      5'd2:  b = 4'd5;
      5'd3:  b = 4'd1;
      5'd4:  b = 4'd0;
      5'd5:  b = 4'd4;
      5'd6:  b = 4'd3;
      5'd7:  b = 4'd0;
      5'd8:  b = 4'd0;
      5'd9:  b = 4'd14;
      5'd10: b = 4'd5;
      5'd11: b = 4'd2;
      5'd12: b = 4'd3;
      5'd13: b = 4'd1;
      5'd14: b = 4'd7;
      5'd15: b = 4'd6;
      5'd16: b = 4'd11;
      5'd17: b = 4'd2;
      5'd18: b = 4'd0;
      5'd19: b = 4'd1;
      5'd20: b = 4'd4;
      5'd21: b = 4'd8;
      5'd22: b = 4'd6;
      5'd23: b = 4'd9;
      5'd24: b = 4'd13;
      5'd25: b = 4'd3;
      default: b = 4'd0;
    endcase
    return b;
  endfunction

  function automatic logic [15:0] at_least_one(input logic [15:0] v);
    return (v == 16'd0) ? 16'd1 : v;
  endfunction

endpackage

`default_nettype wire

[rtl/morse_line_player.sv]
// channel  | dir | tdata                     | tuser
// s_axis   | in  | [7:0] byte_value          | mode (0 byte, 1 tick)
// m_axis   | out | tone_led, red_led,        | -
//          |     | busy_res, dropped,        |
//          |     | symbol_code[4:0], 0 pad   |
// cfg      | in  | cfg_we, cfg_addr, cfg_data (dot, dash, gap, error time)
//
// one request per clock while s_tready is high: the whole step is done in the cycle it is
// accepted and the result lands in a two-entry output queue
// the line buffer read is registered and kept one character ahead of playback
// s_tready drops only while both output entries wait to be taken
// rst (synchronous) empties the line, stops playback and loads the default times
`default_nettype none
`include "assert_macros.svh"

module morse_line_player
  import mlp_pkg::*;
#(
  parameter int LINE_DEPTH = 128
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] byte_value
  input  wire logic        s_tuser,   // [0] mode
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // [0] tone_led, [1] red_led, [2] busy_res,
                                      // [3] dropped, [8:4] symbol_code, rest zero
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_addr,
  input  wire logic [15:0] cfg_data
);

  localparam int ADDR_W = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(LINE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(LINE_DEPTH);

  // configuration
  logic [15:0] dot_time, dash_time, gap_time, error_time;

  always_ff @(posedge clk) begin
    if (rst) begin
      dot_time   <= DOT_RESET;
      dash_time  <= DASH_RESET;
      gap_time   <= GAP_RESET;
      error_time <= ERROR_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_DOT_TIME:   dot_time   <= cfg_data;
        REG_DASH_TIME:  dash_time  <= cfg_data;
        REG_GAP_TIME:   gap_time   <= cfg_data;
        REG_ERROR_TIME: error_time <= cfg_data;
      endcase
    end
  end

  // playback state
  logic             playing, playing_next;
  logic [CNT_W-1:0] fill_count, fill_count_next;
  logic [CNT_W-1:0] play_index, play_index_next;
  logic [1:0]       element_index, element_index_next;
  logic             in_gap, in_gap_next;
  logic [15:0]      tick_countdown, tick_countdown_next;
  logic [4:0]       current_symbol, current_symbol_next;

  // line buffer
  logic [7:0]       line_buffer [LINE_DEPTH];
  logic [7:0]       rd_data;
  logic             mem_we;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [CNT_W-1:0] rd_cnt;

  // output queue
  result_t          q0, q1;
  logic [1:0]       out_cnt;
  result_t          res;
  logic             accept, pop;

  assign s_tready = (out_cnt != 2'd2);
  assign accept   = s_tvalid && s_tready;
  assign pop      = m_tvalid && m_tready;
  assign m_tvalid = (out_cnt != 2'd0);
  assign m_tdata  = {7'd0, q0};

  // character load, shared by the carriage return and the end of a character
  logic             cr_start;
  logic [CNT_W-1:0] load_idx;
  logic             load_end;
  logic             load_letter;
  logic [4:0]       load_pos;
  logic [3:0]       load_bits;
  logic [15:0]      load_cd;

  // element step within the current letter
  logic [4:0]       cur_pos;
  logic [3:0]       cur_bits;
  logic [2:0]       cur_len;
  logic [1:0]       elem_inc;
  logic             more_elems;
  logic [15:0]      elem_cd;
  logic [15:0]      cd_dec;
  logic             dropped;

  always_comb begin
    load_letter = (rd_data >= CHAR_A) && (rd_data <= CHAR_Z);
    load_pos    = 5'(rd_data - CHAR_A);
    load_bits   = morse_bits(load_pos);
    if (load_letter) begin
      load_cd = at_least_one(load_bits[0] ? dash_time : dot_time);
    end else begin
      load_cd = at_least_one(error_time);
    end

    cur_pos    = 5'(current_symbol - 5'd1);
    cur_bits   = morse_bits(cur_pos);
    cur_len    = morse_len(cur_pos);
    elem_inc   = 2'(element_index + 2'd1);
    more_elems = ({1'b0, element_index} + 3'd1) < cur_len;
    elem_cd    = at_least_one(cur_bits[elem_inc] ? dash_time : dot_time);
    cd_dec     = (tick_countdown != 16'd0) ? 16'(tick_countdown - 16'd1) : 16'd0;
  end

  always_comb begin
    playing_next        = playing;
    fill_count_next     = fill_count;
    play_index_next     = play_index;
    element_index_next  = element_index;
    in_gap_next         = in_gap;
    tick_countdown_next = tick_countdown;
    current_symbol_next = current_symbol;
    mem_we              = 1'b0;
    dropped             = 1'b0;
    cr_start            = 1'b0;
    load_idx            = CNT_W'(play_index + CNT_W'(1));
    load_end            = 1'b0;

    if (accept) begin
      if (s_tuser) begin
        if (playing) begin
          tick_countdown_next = cd_dec;
          if (cd_dec == 16'd0) begin
            priority if ((current_symbol == SYM_INVALID) || (current_symbol == SYM_NONE)) begin
              load_end = 1'b1;
            end else if (!in_gap && (gap_time != 16'd0)) begin
              in_gap_next         = 1'b1;
              tick_countdown_next = gap_time;
            end else if (more_elems) begin
              element_index_next  = elem_inc;
              in_gap_next         = 1'b0;
              tick_countdown_next = elem_cd;
            end else begin
              load_end = 1'b1;
            end
          end
        end
      end else if (playing) begin
        dropped = 1'b1;
      end else if (s_tdata == CR_CODE) begin
        if (fill_count != '0) begin
          cr_start = 1'b1;
          load_idx = '0;
        end
      end else if (fill_count < DEPTH_CNT) begin
        mem_we          = 1'b1;
        fill_count_next = CNT_W'(fill_count + CNT_W'(1));
      end else begin
        dropped = 1'b1;
      end
    end

    // load_end here means "advance to the next character"
    if (cr_start || load_end) begin
      play_index_next    = load_idx;
      element_index_next = 2'd0;
      in_gap_next        = 1'b0;
      if (load_idx >= fill_count) begin
        playing_next        = 1'b0;
        fill_count_next     = '0;
        play_index_next     = '0;
        tick_countdown_next = 16'd0;
        current_symbol_next = SYM_NONE;
      end else begin
        playing_next        = 1'b1;
        tick_countdown_next = load_cd;
        current_symbol_next = load_letter ? 5'(load_pos + 5'd1) : SYM_INVALID;
      end
    end

    res.tone_led    = playing_next && (current_symbol_next != SYM_NONE)
                      && (current_symbol_next <= SYM_LAST) && !in_gap_next;
    res.red_led     = playing_next && (current_symbol_next == SYM_INVALID);
    res.busy_res    = playing_next;
    res.dropped     = dropped;
    res.symbol_code = playing_next ? current_symbol_next : SYM_NONE;
  end

  // keep the read one character ahead of the one being shown
  always_comb begin
    wr_addr = fill_count[ADDR_W-1:0];
    rd_cnt  = playing_next ? CNT_W'(play_index_next + CNT_W'(1)) : '0;
    rd_addr = rd_cnt[ADDR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_buffer[wr_addr] <= s_tdata;
    end
    // write-through so a byte just stored is seen by the next carriage return
    if (mem_we && (wr_addr == rd_addr)) begin
      rd_data <= s_tdata;
    end else begin
      rd_data <= line_buffer[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      playing        <= 1'b0;
      fill_count     <= '0;
      play_index     <= '0;
      element_index  <= 2'd0;
      in_gap         <= 1'b0;
      tick_countdown <= 16'd0;
      current_symbol <= SYM_NONE;
    end else begin
      playing        <= playing_next;
      fill_count     <= fill_count_next;
      play_index     <= play_index_next;
      element_index  <= element_index_next;
      in_gap         <= in_gap_next;
      tick_countdown <= tick_countdown_next;
      current_symbol <= current_symbol_next;
    end
  end

  // two-entry output queue, head in q0
  always_ff @(posedge clk) begin
    if (rst) begin
      out_cnt <= 2'd0;
    end else begin
      out_cnt <= 2'(out_cnt + {1'b0, accept} - {1'b0, pop});
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      q0 <= (out_cnt == 2'd2) ? q1 : res;
      if (accept && (out_cnt == 2'd2)) begin
        q1 <= res;
      end
    end else if (accept) begin
      if (out_cnt == 2'd0) begin
        q0 <= res;
      end else begin
        q1 <= res;
      end
    end
  end

  `ASSERT_ALWAYS(a_play_has_line, clk, rst, !playing || (fill_count != '0))
  `ASSERT_ALWAYS(a_idle_clean, clk, rst,
    playing || ((play_index == '0) && (tick_countdown == 16'd0)
                && (current_symbol == SYM_NONE)))
  `ASSERT_ALWAYS(a_gap_on_letter, clk, rst,
    !in_gap || (playing && (current_symbol != SYM_NONE) && (current_symbol != SYM_INVALID)))
  `ASSERT_NEXT(a_no_store_while_playing, clk, rst,
    accept && !s_tuser && playing, $stable(fill_count))
  `ASSERT_ALWAYS(a_queue_bound, clk, rst, out_cnt != 2'd3)

endmodule

`default_nettype wire
